// File: hw/rtl/arcd_pkg.sv
// Package for the ASCII robot command decoder.
// Holds the shared types, character codes and the duty arithmetic helper.
// No dependencies.
package arcd_pkg;

  // Only the first slots of a frame are ever decoded.
  localparam int unsigned READ_SLOTS = 10;

  // Command queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [7:0] CH_BANG  = 8'h21; // '!'
  localparam logic [7:0] CH_HASH  = 8'h23; // '#'
  localparam logic [7:0] CH_AT    = 8'h40; // '@'
  localparam logic [7:0] CH_QUERY = 8'h3F; // '?'
  localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
  localparam logic [7:0] CH_ONE   = 8'h31; // '1'
  localparam logic [7:0] CH_TWO   = 8'h32; // '2'
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;

  localparam logic [7:0] DUTY_QUICK  = 8'd80;
  localparam logic [7:0] DIR_FORWARD = 8'd1;

  localparam logic [1:0] SENSOR_SUPPLY = 2'd0;
  localparam logic [1:0] SENSOR_FRONT  = 2'd1;
  localparam logic [1:0] SENSOR_BACK   = 2'd2;

  localparam logic [1:0] MASK_NONE  = 2'b00;
  localparam logic [1:0] MASK_RIGHT = 2'b01;
  localparam logic [1:0] MASK_LEFT  = 2'b10;
  localparam logic [1:0] MASK_BOTH  = 2'b11;

  typedef enum logic [2:0] {
    ACT_STOP   = 3'd0,
    ACT_DRIVE  = 3'd1,
    ACT_PWM    = 3'd2,
    ACT_DIR    = 3'd3,
    ACT_SENSOR = 3'd4,
    ACT_LED    = 3'd5,
    ACT_SAFETY = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_QUICK = 2'd2
  } kind_e;

  // One classified command as it travels from the front to the back.
  typedef struct packed {
    kind_e                       kind;
    logic [READ_SLOTS-1:0][7:0] slots;
  } cmd_t;

  function automatic logic [7:0] digit(input logic [7:0] ch);
    digit = ch - CH_ZERO;
  endfunction

  // Three-digit decimal value, kept modulo 256.
  function automatic logic [7:0] duty(input logic [7:0] c0, input logic [7:0] c1,
                                      input logic [7:0] c2);
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
    d0   = digit(c0);
    d1   = digit(c1);
    d2   = digit(c2);
    duty = 8'(d0 * 8'd100) + 8'(d1 * 8'd10) + d2;
  endfunction

endpackage

// File: hw/rtl/ascii_robot_command_decoder.sv
// Top level of the ASCII robot command decoder.
// Throughput: one byte per cycle while the command queue is not full. A command
// byte's result is registered into the command queue, then into the result register.
// Reset (rst_ni, asynchronous, active low) clears the frame, the index, both LEDs
// and the safety flag, and empties the queue and the result register.
// Depends on arcd_pkg, arcd_front, arcd_queue and arcd_back.
module ascii_robot_command_decoder #(
  parameter int unsigned FRAME_DEPTH = 15
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] action_o,
  output logic [1:0] motor_mask_o,
  output logic [7:0] right_direction_o,
  output logic [7:0] right_pwm_o,
  output logic [7:0] left_direction_o,
  output logic [7:0] left_pwm_o,
  output logic [1:0] sensor_select_o,
  output logic       blue_led_on_o,
  output logic       red_led_on_o,
  output logic       safety_on_o
);

  // The front takes one transfer per cycle unless the command queue is full.
  // Frame bytes, '!' and bytes that only update the store never need the
  // back part, but stalling on a full queue keeps the control simple.
  logic           accept;
  logic           push;
  logic           full;
  logic           pop;
  logic           head_valid;
  arcd_pkg::cmd_t cmd;
  arcd_pkg::cmd_t head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  arcd_front #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .cmd_o     (cmd)
  );

  // The queue decouples the front from a stalled result register, so bytes keep
  // flowing while a finished result waits to be taken.
  arcd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // The back decodes the frame snapshot, updates LED and safety state in
  // command order and drives the result register.
  arcd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_valid_i      (head_valid),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .action_o          (action_o),
    .motor_mask_o      (motor_mask_o),
    .right_direction_o (right_direction_o),
    .right_pwm_o       (right_pwm_o),
    .left_direction_o  (left_direction_o),
    .left_pwm_o        (left_pwm_o),
    .sensor_select_o   (sensor_select_o),
    .blue_led_on_o     (blue_led_on_o),
    .red_led_on_o      (red_led_on_o),
    .safety_on_o       (safety_on_o)
  );

endmodule

// File: hw/rtl/arcd_front.sv
// Front part of the ASCII robot command decoder: accepts bytes, keeps the frame.
// Classifies command bytes and pushes them into the command queue.
// Depends on arcd_pkg.
module arcd_front #(
  parameter int unsigned FRAME_DEPTH = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  output logic              push_o,
  output arcd_pkg::cmd_t    cmd_o
);

  localparam int unsigned IDX_W = $clog2(FRAME_DEPTH);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       slot_q [arcd_pkg::READ_SLOTS];
  logic [7:0]       slot_d [arcd_pkg::READ_SLOTS];

  always_comb begin
    idx_d  = idx_q;
    slot_d = slot_q;
    push_o = 1'b0;
    cmd_o.kind = arcd_pkg::KIND_FRAME;
    if (accept_i) begin
      case (rx_byte_i)
        arcd_pkg::CH_BANG: begin
          idx_d = '0;
        end
        arcd_pkg::CH_HASH: begin
          for (int i = 0; i < arcd_pkg::READ_SLOTS; i++) begin
            if (idx_q == IDX_W'(i)) slot_d[i] = 8'd0;
          end
          push_o = 1'b1;
        end
        arcd_pkg::CH_AT: begin
          cmd_o.kind = arcd_pkg::KIND_STOP;
          push_o     = 1'b1;
        end
        arcd_pkg::CH_QUERY: begin
          cmd_o.kind = arcd_pkg::KIND_QUICK;
          push_o     = 1'b1;
        end
        default: begin
          for (int i = 0; i < arcd_pkg::READ_SLOTS; i++) begin
            if (idx_q == IDX_W'(i)) slot_d[i] = rx_byte_i;
          end
          idx_d = (idx_q == IDX_W'(FRAME_DEPTH - 1)) ? '0 : idx_q + 1'b1;
        end
      endcase
    end
    // The frame snapshot includes the end mark written in this transfer.
    for (int i = 0; i < arcd_pkg::READ_SLOTS; i++) begin
      cmd_o.slots[i] = slot_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      for (int i = 0; i < arcd_pkg::READ_SLOTS; i++) slot_q[i] <= 8'd0;
    end else begin
      idx_q  <= idx_d;
      slot_q <= slot_d;
    end
  end

endmodule

// File: hw/rtl/arcd_queue.sv
// Two-entry command queue between the front and back parts.
// Depends on arcd_pkg.
module arcd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  arcd_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output arcd_pkg::cmd_t head_o
);

  arcd_pkg::cmd_t                mem_q [arcd_pkg::QUEUE_DEPTH];
  logic [arcd_pkg::QPTR_W-1:0]   wr_q, rd_q;
  logic [arcd_pkg::QCNT_W-1:0]   cnt_q;
  logic                          do_push, do_pop;

  assign full_o       = (cnt_q == arcd_pkg::QCNT_W'(arcd_pkg::QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: hw/rtl/arcd_back.sv
// Back part of the ASCII robot command decoder: decodes queued commands,
// owns the LED and safety flags and holds the result register.
// Depends on arcd_pkg.
module arcd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  arcd_pkg::cmd_t       head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           action_o,
  output logic [1:0]           motor_mask_o,
  output logic [7:0]           right_direction_o,
  output logic [7:0]           right_pwm_o,
  output logic [7:0]           left_direction_o,
  output logic [7:0]           left_pwm_o,
  output logic [1:0]           sensor_select_o,
  output logic                 blue_led_on_o,
  output logic                 red_led_on_o,
  output logic                 safety_on_o
);

  logic             out_valid_q;
  logic             blue_q, blue_d, red_q, red_d, safety_q, safety_d;
  logic             res_valid;
  arcd_pkg::action_e act;
  logic [1:0]       mask;
  logic [7:0]       rdir, rpwm, ldir, lpwm;
  logic [1:0]       sensor;
  logic [7:0]       c0, c1, c2;
  logic [7:0]       duty3;
  logic             load;

  logic [2:0]       action_q;
  logic [1:0]       mask_q, sensor_q;
  logic [7:0]       rdir_q, rpwm_q, ldir_q, lpwm_q;
  logic             blue_out_q, red_out_q, safety_out_q;

  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load;

  assign c0    = head_i.slots[0];
  assign c1    = head_i.slots[1];
  assign c2    = head_i.slots[2];
  assign duty3 = arcd_pkg::duty(head_i.slots[3], head_i.slots[4], head_i.slots[5]);

  always_comb begin
    res_valid = 1'b0;
    act       = arcd_pkg::ACT_STOP;
    mask      = arcd_pkg::MASK_NONE;
    rdir      = 8'd0;
    rpwm      = 8'd0;
    ldir      = 8'd0;
    lpwm      = 8'd0;
    sensor    = arcd_pkg::SENSOR_SUPPLY;
    blue_d    = blue_q;
    red_d     = red_q;
    safety_d  = safety_q;
    case (head_i.kind)
      arcd_pkg::KIND_STOP: begin
        res_valid = 1'b1;
        mask      = arcd_pkg::MASK_BOTH;
      end
      arcd_pkg::KIND_QUICK: begin
        res_valid = 1'b1;
        act       = arcd_pkg::ACT_DRIVE;
        mask      = arcd_pkg::MASK_BOTH;
        rdir      = arcd_pkg::DIR_FORWARD;
        ldir      = arcd_pkg::DIR_FORWARD;
        rpwm      = arcd_pkg::DUTY_QUICK;
        lpwm      = arcd_pkg::DUTY_QUICK;
      end
      arcd_pkg::KIND_FRAME: begin
        case (c0)
          arcd_pkg::CH_A: begin
            act = arcd_pkg::ACT_SENSOR;
            if (c1 == arcd_pkg::CH_P) begin
              res_valid = 1'b1;
            end else if (c1 == arcd_pkg::CH_F) begin
              res_valid = 1'b1;
              sensor    = arcd_pkg::SENSOR_FRONT;
            end else if (c1 == arcd_pkg::CH_B) begin
              res_valid = 1'b1;
              sensor    = arcd_pkg::SENSOR_BACK;
            end
          end
          arcd_pkg::CH_L: begin
            act = arcd_pkg::ACT_LED;
            if (c1 == arcd_pkg::CH_B || c1 == arcd_pkg::CH_R) begin
              res_valid = (c2 == arcd_pkg::CH_S) || (c2 == arcd_pkg::CH_R) ||
                          (c2 == arcd_pkg::CH_T);
              if (c1 == arcd_pkg::CH_B) begin
                if (c2 == arcd_pkg::CH_S)      blue_d = 1'b1;
                else if (c2 == arcd_pkg::CH_R) blue_d = 1'b0;
                else if (c2 == arcd_pkg::CH_T) blue_d = !blue_q;
              end else begin
                if (c2 == arcd_pkg::CH_S)      red_d = 1'b1;
                else if (c2 == arcd_pkg::CH_R) red_d = 1'b0;
                else if (c2 == arcd_pkg::CH_T) red_d = !red_q;
              end
            end
          end
          arcd_pkg::CH_M: begin
            if (c1 == arcd_pkg::CH_S) begin
              res_valid = 1'b1;
              mask      = arcd_pkg::MASK_BOTH;
            end else if (c1 == arcd_pkg::CH_B) begin
              res_valid = 1'b1;
              act       = arcd_pkg::ACT_DRIVE;
              mask      = arcd_pkg::MASK_BOTH;
              rdir      = arcd_pkg::digit(head_i.slots[2]);
              rpwm      = duty3;
              ldir      = arcd_pkg::digit(head_i.slots[6]);
              lpwm      = arcd_pkg::duty(head_i.slots[7], head_i.slots[8],
                                         head_i.slots[9]);
            end else if (c1 == arcd_pkg::CH_P) begin
              act = arcd_pkg::ACT_PWM;
              if (c2 == arcd_pkg::CH_ONE) begin
                res_valid = 1'b1;
                mask      = arcd_pkg::MASK_RIGHT;
                rpwm      = duty3;
              end else if (c2 == arcd_pkg::CH_TWO) begin
                res_valid = 1'b1;
                mask      = arcd_pkg::MASK_LEFT;
                lpwm      = duty3;
              end else if (c2 == arcd_pkg::CH_B) begin
                res_valid = 1'b1;
                mask      = arcd_pkg::MASK_BOTH;
                rpwm      = duty3;
                lpwm      = duty3;
              end
            end else if (c1 == arcd_pkg::CH_D) begin
              res_valid = 1'b1;
              act       = arcd_pkg::ACT_DIR;
              mask      = arcd_pkg::MASK_BOTH;
              rdir      = arcd_pkg::digit(head_i.slots[2]);
              ldir      = arcd_pkg::digit(head_i.slots[3]);
            end else if (c1 == arcd_pkg::CH_ONE) begin
              res_valid = 1'b1;
              act       = arcd_pkg::ACT_DRIVE;
              mask      = arcd_pkg::MASK_RIGHT;
              rdir      = arcd_pkg::digit(head_i.slots[2]);
              rpwm      = duty3;
            end else if (c1 == arcd_pkg::CH_TWO) begin
              res_valid = 1'b1;
              act       = arcd_pkg::ACT_DRIVE;
              mask      = arcd_pkg::MASK_LEFT;
              ldir      = arcd_pkg::digit(head_i.slots[2]);
              lpwm      = duty3;
            end
          end
          arcd_pkg::CH_S: begin
            act = arcd_pkg::ACT_SAFETY;
            if (c1 == arcd_pkg::CH_S) begin
              res_valid = 1'b1;
              safety_d  = 1'b1;
            end else if (c1 == arcd_pkg::CH_R) begin
              res_valid = 1'b1;
              safety_d  = 1'b0;
            end
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      blue_q      <= 1'b0;
      red_q       <= 1'b0;
      safety_q    <= 1'b0;
    end else if (load) begin
      out_valid_q <= res_valid;
      blue_q      <= blue_d;
      red_q       <= red_d;
      safety_q    <= safety_d;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && res_valid) begin
      action_q     <= act;
      mask_q       <= mask;
      rdir_q       <= rdir;
      rpwm_q       <= rpwm;
      ldir_q       <= ldir;
      lpwm_q       <= lpwm;
      sensor_q     <= sensor;
      blue_out_q   <= blue_d;
      red_out_q    <= red_d;
      safety_out_q <= safety_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign action_o          = action_q;
  assign motor_mask_o      = mask_q;
  assign right_direction_o = rdir_q;
  assign right_pwm_o       = rpwm_q;
  assign left_direction_o  = ldir_q;
  assign left_pwm_o        = lpwm_q;
  assign sensor_select_o   = sensor_q;
  assign blue_led_on_o     = blue_out_q;
  assign red_led_on_o      = red_out_q;
  assign safety_on_o       = safety_out_q;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for ascii_robot_command_decoder: random and directed byte
// streams, a built-in command predictor and an in-order result scoreboard.
// Depends on arcd_pkg and the decoder RTL only.
module testbench;

  localparam int FRAME_DEPTH  = 15;
  localparam int RANDOM_BYTES = 650;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_REPORTS  = 10;

  // One decoded command as it leaves the block.
  typedef struct packed {
    arcd_pkg::action_e action;
    logic [1:0]        motor_mask;
    logic [7:0]        right_direction;
    logic [7:0]        right_pwm;
    logic [7:0]        left_direction;
    logic [7:0]        left_pwm;
    logic [1:0]        sensor_select;
    logic              blue_led_on;
    logic              red_led_on;
    logic              safety_on;
  } command_t;

  // Clock and reset. Every input of the block starts at a known value.
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;

  logic       in_stall_o;
  logic       out_valid_o;
  logic [2:0] action_o;
  logic [1:0] motor_mask_o;
  logic [7:0] right_direction_o;
  logic [7:0] right_pwm_o;
  logic [7:0] left_direction_o;
  logic [7:0] left_pwm_o;
  logic [1:0] sensor_select_o;
  logic       blue_led_on_o;
  logic       red_led_on_o;
  logic       safety_on_o;

  // Bytes waiting to be sent and commands waiting to come out.
  logic [7:0] pending_bytes[$];
  command_t   expected_cmds[$];

  // Predictor state: a private copy of the frame buffer, index and flags.
  logic [7:0] frame_buf[FRAME_DEPTH];
  int         wr_slot;
  logic       blue_state;
  logic       red_state;
  logic       safety_state;

  int total_bytes  = 0;
  int sent_bytes   = 0;
  int rx_transfers = 0;
  int cycle_cnt    = 0;
  int mismatches   = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ascii_robot_command_decoder #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .action_o         (action_o),
    .motor_mask_o     (motor_mask_o),
    .right_direction_o(right_direction_o),
    .right_pwm_o      (right_pwm_o),
    .left_direction_o (left_direction_o),
    .left_pwm_o       (left_pwm_o),
    .sensor_select_o  (sensor_select_o),
    .blue_led_on_o    (blue_led_on_o),
    .red_led_on_o     (red_led_on_o),
    .safety_on_o      (safety_on_o)
  );

  // ---------------------------------------------------------------------------
  // Command predictor
  // ---------------------------------------------------------------------------

  // A stored character read as a digit. Non-digits wrap modulo 256.
  function automatic logic [7:0] digit_at(input int idx);
    return frame_buf[idx] - arcd_pkg::CH_ZERO;
  endfunction

  // Three-digit decimal duty starting at a slot, truncated to eight bits.
  function automatic logic [7:0] duty_at(input int idx);
    int unsigned sum;
    sum = 100 * digit_at(idx) + 10 * digit_at(idx + 1) + digit_at(idx + 2);
    return sum[7:0];
  endfunction

  // The flag fields always carry the state after the current byte.
  function automatic command_t make_cmd(input arcd_pkg::action_e act,
                                        input logic [1:0] mask,
                                        input logic [7:0] rdir, input logic [7:0] rpwm,
                                        input logic [7:0] ldir, input logic [7:0] lpwm,
                                        input logic [1:0] sensor);
    command_t c;
    c.action          = act;
    c.motor_mask      = mask;
    c.right_direction = rdir;
    c.right_pwm       = rpwm;
    c.left_direction  = ldir;
    c.left_pwm        = lpwm;
    c.sensor_select   = sensor;
    c.blue_led_on     = blue_state;
    c.red_led_on      = red_state;
    c.safety_on       = safety_state;
    return c;
  endfunction

  // Set, reset or toggle one LED. Returns 0 when the operation letter is unknown.
  function automatic bit led_update(inout logic led, input logic [7:0] op);
    bit known;
    known = 1'b1;
    if (op == arcd_pkg::CH_S) led = 1'b1;
    else if (op == arcd_pkg::CH_R) led = 1'b0;
    else if (op == arcd_pkg::CH_T) led = ~led;
    else known = 1'b0;
    return known;
  endfunction

  // Decode the frame held in the buffer. Unknown frames give nothing and
  // leave the flags untouched.
  task automatic decode_frame(output command_t cmd, output bit hit);
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] pwm;
    c0  = frame_buf[0];
    c1  = frame_buf[1];
    c2  = frame_buf[2];
    hit = 1'b0;
    cmd = '0;
    if (c0 == arcd_pkg::CH_A) begin
      hit = 1'b1;
      if (c1 == arcd_pkg::CH_P)
        cmd = make_cmd(arcd_pkg::ACT_SENSOR, arcd_pkg::MASK_NONE, '0, '0, '0, '0,
                       arcd_pkg::SENSOR_SUPPLY);
      else if (c1 == arcd_pkg::CH_F)
        cmd = make_cmd(arcd_pkg::ACT_SENSOR, arcd_pkg::MASK_NONE, '0, '0, '0, '0,
                       arcd_pkg::SENSOR_FRONT);
      else if (c1 == arcd_pkg::CH_B)
        cmd = make_cmd(arcd_pkg::ACT_SENSOR, arcd_pkg::MASK_NONE, '0, '0, '0, '0,
                       arcd_pkg::SENSOR_BACK);
      else hit = 1'b0;
    end else if (c0 == arcd_pkg::CH_L) begin
      if (c1 == arcd_pkg::CH_B) hit = led_update(blue_state, c2);
      else if (c1 == arcd_pkg::CH_R) hit = led_update(red_state, c2);
      if (hit)
        cmd = make_cmd(arcd_pkg::ACT_LED, arcd_pkg::MASK_NONE, '0, '0, '0, '0,
                       arcd_pkg::SENSOR_SUPPLY);
    end else if (c0 == arcd_pkg::CH_M) begin
      hit = 1'b1;
      pwm = duty_at(3);
      if (c1 == arcd_pkg::CH_S) begin
        cmd = make_cmd(arcd_pkg::ACT_STOP, arcd_pkg::MASK_BOTH, '0, '0, '0, '0,
                       arcd_pkg::SENSOR_SUPPLY);
      end else if (c1 == arcd_pkg::CH_B) begin
        cmd = make_cmd(arcd_pkg::ACT_DRIVE, arcd_pkg::MASK_BOTH, digit_at(2), duty_at(3),
                       digit_at(6), duty_at(7), arcd_pkg::SENSOR_SUPPLY);
      end else if (c1 == arcd_pkg::CH_P) begin
        if (c2 == arcd_pkg::CH_ONE)
          cmd = make_cmd(arcd_pkg::ACT_PWM, arcd_pkg::MASK_RIGHT, '0, pwm, '0, '0,
                         arcd_pkg::SENSOR_SUPPLY);
        else if (c2 == arcd_pkg::CH_TWO)
          cmd = make_cmd(arcd_pkg::ACT_PWM, arcd_pkg::MASK_LEFT, '0, '0, '0, pwm,
                         arcd_pkg::SENSOR_SUPPLY);
        else if (c2 == arcd_pkg::CH_B)
          cmd = make_cmd(arcd_pkg::ACT_PWM, arcd_pkg::MASK_BOTH, '0, pwm, '0, pwm,
                         arcd_pkg::SENSOR_SUPPLY);
        else hit = 1'b0;
      end else if (c1 == arcd_pkg::CH_D) begin
        cmd = make_cmd(arcd_pkg::ACT_DIR, arcd_pkg::MASK_BOTH, digit_at(2), '0,
                       digit_at(3), '0, arcd_pkg::SENSOR_SUPPLY);
      end else if (c1 == arcd_pkg::CH_ONE) begin
        cmd = make_cmd(arcd_pkg::ACT_DRIVE, arcd_pkg::MASK_RIGHT, digit_at(2), pwm, '0, '0,
                       arcd_pkg::SENSOR_SUPPLY);
      end else if (c1 == arcd_pkg::CH_TWO) begin
        cmd = make_cmd(arcd_pkg::ACT_DRIVE, arcd_pkg::MASK_LEFT, '0, '0, digit_at(2), pwm,
                       arcd_pkg::SENSOR_SUPPLY);
      end else begin
        // A single-motor drive with an id other than right or left is dropped.
        hit = 1'b0;
      end
    end else if (c0 == arcd_pkg::CH_S) begin
      hit = 1'b1;
      if (c1 == arcd_pkg::CH_S) safety_state = 1'b1;
      else if (c1 == arcd_pkg::CH_R) safety_state = 1'b0;
      else hit = 1'b0;
      if (hit)
        cmd = make_cmd(arcd_pkg::ACT_SAFETY, arcd_pkg::MASK_NONE, '0, '0, '0, '0,
                       arcd_pkg::SENSOR_SUPPLY);
    end
  endtask

  // Advance the predictor by one accepted byte and queue any command it causes.
  task automatic predict_byte(input logic [7:0] b);
    command_t cmd;
    bit       hit;
    if (wr_slot >= FRAME_DEPTH) wr_slot = 0;
    case (b)
      arcd_pkg::CH_BANG: wr_slot = 0;
      arcd_pkg::CH_HASH: begin
        // The end mark is stored as a zero but does not move the index.
        frame_buf[wr_slot] = 8'h00;
        decode_frame(cmd, hit);
        if (hit) expected_cmds.push_back(cmd);
      end
      arcd_pkg::CH_AT: begin
        expected_cmds.push_back(make_cmd(arcd_pkg::ACT_STOP, arcd_pkg::MASK_BOTH,
                                         '0, '0, '0, '0, arcd_pkg::SENSOR_SUPPLY));
      end
      arcd_pkg::CH_QUERY: begin
        expected_cmds.push_back(make_cmd(arcd_pkg::ACT_DRIVE, arcd_pkg::MASK_BOTH,
                                         arcd_pkg::DIR_FORWARD, arcd_pkg::DUTY_QUICK,
                                         arcd_pkg::DIR_FORWARD, arcd_pkg::DUTY_QUICK,
                                         arcd_pkg::SENSOR_SUPPLY));
      end
      default: begin
        frame_buf[wr_slot] = b;
        wr_slot++;
        if (wr_slot > FRAME_DEPTH - 1) wr_slot = 0;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly a decimal digit, sometimes any byte so non-digits get decoded too.
  function automatic logic [7:0] some_digit();
    if ($urandom_range(0, 99) < 85) return arcd_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    return any_byte();
  endfunction

  // One of three legal letters, or now and then a random byte.
  function automatic logic [7:0] pick_of(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return a;
    if (r < 60) return b;
    if (r < 90) return c;
    return any_byte();
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endtask

  task automatic push_duty();
    repeat (3) pending_bytes.push_back(some_digit());
  endtask

  // One random frame. Most are well formed with random content; the rest are
  // unknown commands, truncated frames that decode stale slots, overlong frames
  // that wrap the index, and raw noise.
  task automatic push_random_frame();
    int kind;
    int len;
    kind = $urandom_range(0, 13);
    if ($urandom_range(0, 99) < 90) pending_bytes.push_back(arcd_pkg::CH_BANG);
    case (kind)
      0: begin
        pending_bytes.push_back(arcd_pkg::CH_L);
        pending_bytes.push_back(pick_of(arcd_pkg::CH_B, arcd_pkg::CH_R, arcd_pkg::CH_B));
        pending_bytes.push_back(pick_of(arcd_pkg::CH_S, arcd_pkg::CH_R, arcd_pkg::CH_T));
      end
      1: begin
        pending_bytes.push_back(arcd_pkg::CH_A);
        pending_bytes.push_back(pick_of(arcd_pkg::CH_P, arcd_pkg::CH_F, arcd_pkg::CH_B));
      end
      2: push_text("MS");
      3, 4: begin
        push_text("MB");
        pending_bytes.push_back(some_digit());
        push_duty();
        pending_bytes.push_back(some_digit());
        push_duty();
      end
      5: begin
        push_text("MP");
        pending_bytes.push_back(pick_of(arcd_pkg::CH_ONE, arcd_pkg::CH_TWO, arcd_pkg::CH_B));
        push_duty();
      end
      6: begin
        push_text("MD");
        pending_bytes.push_back(some_digit());
        pending_bytes.push_back(some_digit());
      end
      7, 8: begin
        pending_bytes.push_back(arcd_pkg::CH_M);
        pending_bytes.push_back(pick_of(arcd_pkg::CH_ONE, arcd_pkg::CH_TWO,
                                        arcd_pkg::CH_ONE));
        pending_bytes.push_back(some_digit());
        push_duty();
      end
      9: begin
        pending_bytes.push_back(arcd_pkg::CH_S);
        pending_bytes.push_back(pick_of(arcd_pkg::CH_S, arcd_pkg::CH_R, arcd_pkg::CH_S));
      end
      10: begin
        len = $urandom_range(1, 4);
        repeat (len) pending_bytes.push_back(any_byte());
      end
      11: begin
        pending_bytes.push_back(pick_of(arcd_pkg::CH_M, arcd_pkg::CH_L, arcd_pkg::CH_A));
        pending_bytes.push_back(pick_of(arcd_pkg::CH_B, arcd_pkg::CH_P, arcd_pkg::CH_D));
      end
      12: begin
        len = $urandom_range(1, 6);
        repeat (len) pending_bytes.push_back(any_byte());
        if ($urandom_range(0, 1))
          pending_bytes.push_back(pick_of(arcd_pkg::CH_AT, arcd_pkg::CH_QUERY,
                                          arcd_pkg::CH_BANG));
      end
      default: begin
        len = $urandom_range(14, 20);
        repeat (len) pending_bytes.push_back(arcd_pkg::CH_ZERO + 8'($urandom_range(0, 42)));
      end
    endcase
    if ($urandom_range(0, 99) < 95) pending_bytes.push_back(arcd_pkg::CH_HASH);
  endtask

  // Idle rates per phase: the sender idles lightly and the receiver heavily first,
  // then the other way round, then neither idles.
  function automatic int send_idle_pct();
    int phase;
    phase = (sent_bytes * 3) / total_bytes;
    return (phase == 0) ? 28 : (phase == 1) ? 72 : 0;
  endfunction

  function automatic int recv_stall_pct();
    int phase;
    phase = (sent_bytes * 3) / total_bytes;
    return (phase == 0) ? 72 : (phase == 1) ? 28 : 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: a new byte is offered only once the previous transfer completed,
  // so a stalled payload holds still and valid never looks at stall.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= pending_bytes.pop_front();
          sent_bytes++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every input transfer and checks every output transfer
  // against the oldest waiting command.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    command_t got;
    command_t want;
    if (rst_ni) begin
      cycle_cnt++;
      if (in_valid_i && !in_stall_o) begin
        predict_byte(rx_byte_i);
        rx_transfers++;
      end
      if (out_valid_o && !out_stall_i) begin
        got.action          = arcd_pkg::action_e'(action_o);
        got.motor_mask      = motor_mask_o;
        got.right_direction = right_direction_o;
        got.right_pwm       = right_pwm_o;
        got.left_direction  = left_direction_o;
        got.left_pwm        = left_pwm_o;
        got.sensor_select   = sensor_select_o;
        got.blue_led_on     = blue_led_on_o;
        got.red_led_on      = red_led_on_o;
        got.safety_on       = safety_on_o;
        if (expected_cmds.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] unexpected command out: action %0d mask %0d", $realtime,
                     action_o, motor_mask_o);
        end else begin
          want = expected_cmds.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("[%0t] command mismatch", $realtime);
              $display({"  expected act %0d mask %0d r %0d/%0d l %0d/%0d",
                        " sns %0d led %0d%0d saf %0d"},
                       want.action, want.motor_mask, want.right_direction, want.right_pwm,
                       want.left_direction, want.left_pwm, want.sensor_select,
                       want.blue_led_on, want.red_led_on, want.safety_on);
              $display({"  actual   act %0d mask %0d r %0d/%0d l %0d/%0d",
                        " sns %0d led %0d%0d saf %0d"},
                       got.action, got.motor_mask, got.right_direction, got.right_pwm,
                       got.left_direction, got.left_pwm, got.sensor_select,
                       got.blue_led_on, got.red_led_on, got.safety_on);
            end
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the byte stream, reset, wait for the drain, report.
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < FRAME_DEPTH; i++) frame_buf[i] = 8'h00;
    wr_slot      = 0;
    blue_state   = 1'b0;
    red_state    = 1'b0;
    safety_state = 1'b0;

    // Directed part: the immediate stop and quick drive, the byte extremes stored
    // into the frame, safety on, a red toggle, an unknown motor id, a pwm frame
    // that picks up stale slots and non-digit characters, and a back sensor read.
    push_text("@?");
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h00);
    push_text("!SS#");
    push_text("!LRT#");
    push_text("!M3#");
    push_text("!MP2#");
    push_text("!AB#");

    while (pending_bytes.size() < 26 + RANDOM_BYTES) push_random_frame();
    total_bytes = pending_bytes.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_transfers < total_bytes) @(posedge clk_i);
    while (expected_cmds.size() != 0) @(posedge clk_i);
    // Let a late or spurious command surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
